// ----- sv/lgse_pkg.sv -----
// lgse_pkg: opcodes, command and result word types and defaults for the
// life grid step engine. No dependencies.
`timescale 1ns / 1ps

package lgse_pkg;

    localparam int GRID_SIZE_DEF = 64;
    localparam int ADDR_W        = 6;
    localparam int GEN_W         = 32;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] row;
        logic [ADDR_W-1:0] col;
        logic              cell_in;
    } t_cmd;

    typedef struct packed {
        logic             cell_out;
        logic [GEN_W-1:0] generation;
    } t_result;

endpackage

// ----- sv/lgse_row_cell.sv -----
// lgse_row_cell: one grid row held in a register, passed to the next cell
// of the circular row chain on every shift. Uses lgse_pkg.
`timescale 1ns / 1ps

module lgse_row_cell #(
    parameter int GRID_SIZE = lgse_pkg::GRID_SIZE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_shift,
    input  logic [GRID_SIZE-1:0] i_row,
    output logic [GRID_SIZE-1:0] o_row
);
    import lgse_pkg::*;

    logic [GRID_SIZE-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_row <= '0;
        end else if (i_shift) begin
            r_row <= i_row;
        end
    end

    assign o_row = r_row;

endmodule

// ----- sv/lgse_rule_unit.sv -----
// lgse_rule_unit: B3/S23 rule applied to one row from the rows above and
// below, one lane per column, dead cells beyond the edges. Uses lgse_pkg.
`timescale 1ns / 1ps

module lgse_rule_unit #(
    parameter int GRID_SIZE = lgse_pkg::GRID_SIZE_DEF
) (
    input  logic [GRID_SIZE-1:0] i_prev,
    input  logic [GRID_SIZE-1:0] i_cur,
    input  logic [GRID_SIZE-1:0] i_next,
    output logic [GRID_SIZE-1:0] o_row
);
    import lgse_pkg::*;

    logic [GRID_SIZE-1:0] w_pl, w_pr, w_cl, w_cr, w_nl, w_nr;

    assign w_pl = i_prev << 1;
    assign w_pr = i_prev >> 1;
    assign w_cl = i_cur  << 1;
    assign w_cr = i_cur  >> 1;
    assign w_nl = i_next << 1;
    assign w_nr = i_next >> 1;

    always_comb begin
        logic [3:0] v_cnt;
        o_row = '0;
        for (int c = 0; c < GRID_SIZE; c++) begin
            v_cnt = 4'(w_pl[c]) + 4'(i_prev[c]) + 4'(w_pr[c])
                  + 4'(w_cl[c]) + 4'(w_cr[c])
                  + 4'(w_nl[c]) + 4'(i_next[c]) + 4'(w_nr[c]);
            if (v_cnt == 4'd3) begin
                o_row[c] = 1'b1;
            end else if (v_cnt == 4'd2) begin
                o_row[c] = i_cur[c];
            end else begin
                o_row[c] = 1'b0;
            end
        end
    end

endmodule

// ----- sv/life_grid_step_engine.sv -----
// life_grid_step_engine: top level, circular chain of row cells, rule unit
// feeding the chain tail from its head, sequencer and generation counter.
// Uses lgse_pkg, lgse_row_cell and lgse_rule_unit.
`timescale 1ns / 1ps

// Usage:
//   A command word (i_cmd: opcode, row, col, cell_in) is taken at a rising
//   edge with i_start high and o_busy low. Every command gives one result
//   word on o_result, valid for exactly one cycle with o_done high.
//   Clear: grid and generation zeroed at once, result in the following cycle.
//   Write, read and step: the row chain rotates through all GRID_SIZE rows
//   once, one row per cycle past the head; the addressed row is written or
//   sampled as it passes, and a step replaces every row with its next
//   generation from the rows above and below. The result is registered after
//   the last row has passed the head; no new command is taken until then.
//   o_busy is low again in the cycle o_done is high; a new command may be
//   taken then and the shown result stays intact.
//   Reset (synchronous, i_rst_n low) clears every cell and the generation
//   count and drops any command in flight. The receiver cannot stall;
//   each result is taken in its strobe cycle.

module life_grid_step_engine #(
    parameter int GRID_SIZE = lgse_pkg::GRID_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  lgse_pkg::t_cmd    i_cmd,
    output logic              o_busy,
    output logic              o_done,
    output lgse_pkg::t_result o_result
);
    import lgse_pkg::*;

    localparam int            IW   = $clog2(GRID_SIZE);
    localparam logic [IW-1:0] LAST = IW'(GRID_SIZE - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic                 r_state;
    logic [IW-1:0]        r_idx;
    logic [GEN_W-1:0]     r_gen;
    logic                 r_done;
    t_cmd                 r_cmd;
    logic                 r_cell;
    logic [GRID_SIZE-1:0] r_prev;
    t_result              r_res;

    logic [GRID_SIZE-1:0] w_rows [GRID_SIZE];
    logic [GRID_SIZE-1:0] w_head, w_next, w_life, w_tail, w_colmask;
    logic                 w_accept, w_clear, w_shift, w_hit_row, w_last, w_sel;
    logic [GEN_W-1:0]     n_gen;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_clear  = w_accept && (i_cmd.opcode == OP_CLEAR);
    assign w_shift  = (r_state == S_RUN);
    assign w_last   = (r_idx == LAST);
    assign w_head   = w_rows[0];
    assign w_next   = w_last ? '0 : w_rows[1];

    assign w_hit_row = (int'(r_idx) == int'(r_cmd.row));

    always_comb begin
        for (int c = 0; c < GRID_SIZE; c++) begin
            w_colmask[c] = (c == int'(r_cmd.col));
        end
    end

    genvar g;
    generate
        for (g = 0; g < GRID_SIZE; g++) begin : g_cell
            if (g == GRID_SIZE - 1) begin : g_tail
                lgse_row_cell #(.GRID_SIZE(GRID_SIZE)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_clear (w_clear),
                    .i_shift (w_shift),
                    .i_row   (w_tail),
                    .o_row   (w_rows[g])
                );
            end else begin : g_body
                lgse_row_cell #(.GRID_SIZE(GRID_SIZE)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_clear (w_clear),
                    .i_shift (w_shift),
                    .i_row   (w_rows[g+1]),
                    .o_row   (w_rows[g])
                );
            end
        end
    endgenerate

    lgse_rule_unit #(.GRID_SIZE(GRID_SIZE)) u_rule (
        .i_prev (r_prev),
        .i_cur  (w_head),
        .i_next (w_next),
        .o_row  (w_life)
    );

    always_comb begin
        case (r_cmd.opcode)
            OP_STEP: begin
                w_tail = w_life;
            end
            OP_WRITE: begin
                if (w_hit_row) begin
                    w_tail = (w_head & ~w_colmask)
                           | (w_colmask & {GRID_SIZE{r_cmd.cell_in}});
                end else begin
                    w_tail = w_head;
                end
            end
            default: begin
                w_tail = w_head;
            end
        endcase
    end

    assign w_sel = |(w_tail & w_colmask);
    assign n_gen = (r_cmd.opcode == OP_STEP) ? r_gen + GEN_W'(1) : r_gen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_gen   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (w_accept) begin
                r_idx <= '0;
                if (w_clear) begin
                    r_gen  <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_state <= S_RUN;
                end
            end else if (r_state == S_RUN) begin
                r_idx <= r_idx + IW'(1);
                if (w_last) begin
                    r_state <= S_IDLE;
                    r_gen   <= n_gen;
                    r_done  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_cmd;
            r_cell <= 1'b0;
            r_prev <= '0;
            if (w_clear) begin
                r_res <= '{cell_out: 1'b0, generation: '0};
            end
        end else if (r_state == S_RUN) begin
            r_prev <= w_head;
            if (w_hit_row) begin
                r_cell <= w_sel;
            end
            if (w_last) begin
                r_res.cell_out   <= w_hit_row ? w_sel : r_cell;
                r_res.generation <= n_gen;
            end
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ----- sim/tb_life_grid_step_engine.sv -----
// tb_life_grid_step_engine: self-checking bench for the life grid step engine.
// A command-level predictor tracks the grid and generation count and checks
// every result word. Depends on lgse_pkg and life_grid_step_engine.
`timescale 1ns / 1ps

module tb_life_grid_step_engine;

    import lgse_pkg::*;

    localparam int GRID = GRID_SIZE_DEF;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    o_busy;
    logic    o_done;
    t_result o_result;

    bit [GRID-1:0] life_grid [GRID];
    bit [31:0]     life_gen;
    t_result       pending_results[$];

    int mismatch_count = 0;
    int words_sent     = 0;
    int steps_sent     = 0;
    int reads_sent     = 0;
    int results_seen   = 0;

    life_grid_step_engine #(
        .GRID_SIZE(GRID)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_cmd   (i_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 40) begin
            $display("tb: mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // B3/S23 over the old grid; outside cells are dead
    function automatic void advance_grid();
        bit [GRID-1:0] prev [GRID];
        int n;
        int rr;
        int cc;
        prev = life_grid;
        for (int r = 0; r < GRID; r++) begin
            for (int c = 0; c < GRID; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID && cc >= 0 && cc < GRID)
                            n += prev[rr][cc];
                    end
                end
                if (n < 2 || n > 3) begin
                    life_grid[r][c] = 1'b0;
                end else if (n == 3) begin
                    life_grid[r][c] = 1'b1;
                end
            end
        end
        life_gen = life_gen + 32'd1;
    endfunction

    function automatic void predict_result(input t_cmd cmd);
        t_result exp_word;
        bit      in_grid;
        in_grid = (int'(cmd.row) < GRID) && (int'(cmd.col) < GRID);
        case (cmd.opcode)
            OP_WRITE: begin
                if (in_grid) life_grid[cmd.row][cmd.col] = cmd.cell_in;
            end
            OP_CLEAR: begin
                foreach (life_grid[r]) life_grid[r] = '0;
                life_gen = '0;
            end
            OP_STEP: begin
                advance_grid();
            end
            default: begin
            end
        endcase
        exp_word.cell_out   = in_grid ? life_grid[cmd.row][cmd.col] : 1'b0;
        exp_word.generation = life_gen;
        pending_results.push_back(exp_word);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, generation", o_result.generation, 0);
            end else begin
                t_result exp_word;
                exp_word = pending_results.pop_front();
                if (o_result.cell_out !== exp_word.cell_out)
                    report_mismatch("cell_out", o_result.cell_out, exp_word.cell_out);
                if (o_result.generation !== exp_word.generation)
                    report_mismatch("generation", o_result.generation, exp_word.generation);
            end
        end
    end

    task automatic send_word(input t_cmd cmd, input int idle_pct);
        i_start <= 1'b1;
        i_cmd   <= cmd;
        do @(posedge i_clk); while (o_busy);
        predict_result(cmd);
        words_sent++;
        if (cmd.opcode == OP_STEP) steps_sent++;
        if (cmd.opcode == OP_READ) reads_sent++;
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge i_clk);
        end
    endtask

    task automatic send_op(input logic [1:0] op, input logic [5:0] row, input logic [5:0] col,
                           input logic val, input int idle_pct);
        t_cmd cmd;
        cmd.opcode  = op;
        cmd.row     = row;
        cmd.col     = col;
        cmd.cell_in = val;
        send_word(cmd, idle_pct);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_op(OP_READ, 6'd0, 6'd0, 1'b1, 0);
        send_op(OP_READ, 6'd63, 6'd63, 1'b0, 0);
    endtask

    task automatic test_edges_and_corners();
        send_op(OP_WRITE, 6'd0, 6'd0, 1'b1, 0);
        send_op(OP_WRITE, 6'd0, 6'd63, 1'b1, 0);
        send_op(OP_WRITE, 6'd63, 6'd0, 1'b1, 0);
        send_op(OP_WRITE, 6'd63, 6'd63, 1'b1, 0);
        send_op(OP_STEP, 6'd63, 6'd0, 1'b0, 0);
        // blinker lying on the top edge
        send_op(OP_WRITE, 6'd0, 6'd30, 1'b1, 0);
        send_op(OP_WRITE, 6'd0, 6'd31, 1'b1, 0);
        send_op(OP_WRITE, 6'd0, 6'd32, 1'b1, 0);
        send_op(OP_STEP, 6'd1, 6'd31, 1'b1, 0);
        send_op(OP_READ, 6'd0, 6'd30, 1'b0, 0);
        // still-life block in the far corner
        send_op(OP_WRITE, 6'd62, 6'd62, 1'b1, 0);
        send_op(OP_WRITE, 6'd62, 6'd63, 1'b1, 0);
        send_op(OP_WRITE, 6'd63, 6'd62, 1'b1, 0);
        send_op(OP_WRITE, 6'd63, 6'd63, 1'b1, 0);
        send_op(OP_STEP, 6'd63, 6'd63, 1'b0, 0);
        send_op(OP_READ, 6'd62, 6'd62, 1'b1, 0);
    endtask

    task automatic test_clear_and_unused_fields();
        send_op(OP_WRITE, 6'd62, 6'd63, 1'b0, 0);
        send_op(OP_CLEAR, 6'd63, 6'd63, 1'b1, 0);
        send_op(OP_READ, 6'd62, 6'd62, 1'b1, 0);
        send_op(OP_STEP, 6'd42, 6'd21, 1'b1, 0);
        send_op(OP_READ, 6'd21, 6'd42, 1'b0, 0);
    endtask

    // seed a window (may straddle the edge via 6-bit wrap), then evolve and probe it
    task automatic test_random_patterns(input int n_words, input int idle_pct);
        int         target;
        logic [5:0] r0;
        logic [5:0] c0;
        int         span;
        int         density;
        target = words_sent + n_words;
        while (words_sent < target) begin
            if ($urandom_range(3) == 0)
                send_op(OP_CLEAR, 6'($urandom), 6'($urandom), 1'($urandom), idle_pct);
            r0      = ($urandom_range(2) == 0) ? 6'($urandom_range(58, 63)) : 6'($urandom);
            c0      = ($urandom_range(2) == 0) ? 6'($urandom_range(58, 63)) : 6'($urandom);
            span    = $urandom_range(3, 10);
            density = $urandom_range(20, 70);
            repeat ($urandom_range(4, 20)) begin
                send_op(OP_WRITE, r0 + 6'($urandom_range(span - 1)),
                        c0 + 6'($urandom_range(span - 1)),
                        ($urandom_range(99) < density), idle_pct);
            end
            repeat ($urandom_range(1, 6)) begin
                send_op(OP_STEP, 6'($urandom), 6'($urandom), 1'($urandom), idle_pct);
                repeat ($urandom_range(1, 4)) begin
                    send_op(OP_READ, r0 + 6'($urandom_range(span + 1)) - 6'd1,
                            c0 + 6'($urandom_range(span + 1)) - 6'd1, 1'($urandom), idle_pct);
                end
                if ($urandom_range(9) == 0)
                    send_op(2'($urandom), 6'($urandom), 6'($urandom), 1'($urandom), idle_pct);
            end
        end
    endtask

    initial begin
        foreach (life_grid[r]) life_grid[r] = '0;
        life_gen = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_edges_and_corners();
        test_clear_and_unused_fields();
        test_random_patterns(230, 17);
        wait_drained();
        test_random_patterns(230, 45);
        test_random_patterns(230, 0);

        wait_drained();
        repeat (GRID + 8) @(posedge i_clk);

        $display("tb: %0d words sent, %0d steps and %0d reads, edge and corner patterns",
                 words_sent, steps_sent, reads_sent);
        $display("tb: %0d results checked, %0d mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
